FILE: hw/rtl/circular_deque_macros.svh
// Assertion macros for the circular deque.
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// Clocked check, off while reset is asserted.
`define CDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define CDQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/cdq_pkg.sv
// Shared types and constants for the circular deque.
`default_nettype none
package cdq_pkg;

    localparam int CDQ_DEPTH  = 8;
    localparam int CDQ_DATA_W = 32;

    localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHR,
        CELL_SHL,
        CELL_LOAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic [CDQ_DATA_W-1:0]   value;
    } cell_cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cdq_cell.sv
// One storage cell of the deque chain.
`default_nettype none
module cdq_cell
    import cdq_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 4
)
(
    input  wire logic                  clk,
    input  wire cell_cmd_t             cmd,
    input  wire logic [CNT_W-1:0]      count,
    input  wire logic [CDQ_DATA_W-1:0] prev_data,
    input  wire logic [CDQ_DATA_W-1:0] next_data,
    output      logic [CDQ_DATA_W-1:0] data,
    output      logic [CDQ_DATA_W-1:0] tail_data
);

    logic [CDQ_DATA_W-1:0] data_reg;
    logic [CDQ_DATA_W-1:0] data_next;
    logic                  at_free;
    logic                  at_last;

    assign at_free = (count == CNT_W'(CELL_IDX));
    assign at_last = (count == CNT_W'(CELL_IDX + 1));

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_SHR:  data_next = prev_data;
            CELL_SHL:  data_next = next_data;
            CELL_LOAD:
            begin
                if (at_free)
                begin
                    data_next = cmd.value;
                end
            end
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    // masked so the top can OR all cells to find the back entry
    assign tail_data = at_last ? data_reg : '0;

endmodule
`default_nettype wire

FILE: hw/rtl/circular_deque.sv
// Deque as a row of shifting cells: front at cell 0, back at cell count-1.
// Response: a request's response is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle; the response register is the only limit.
// An accepted push or front pop shifts the whole cell row or loads one cell; a back pop only lowers the count.
// Reset: count and response valid clear at once; cell data is not reset.
`default_nettype none
`include "circular_deque_macros.svh"
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = CDQ_DEPTH
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output      logic                         req_stall,
    input  wire logic [1:0]                   req_type,
    input  wire logic signed [CDQ_DATA_W-1:0] push_value,
    output      logic                         rsp_valid,
    input  wire logic                         rsp_stall,
    output      logic [1:0]                   status,
    output      logic signed [CDQ_DATA_W-1:0] popped_value,
    output      logic                         now_empty,
    output      logic                         now_full
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [CDQ_DATA_W-1:0] popped_reg;
    logic [CDQ_DATA_W-1:0] popped_next;
    logic                  empty_reg;
    logic                  full_reg;

    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    logic [CDQ_DATA_W-1:0] tail_value;
    cell_cmd_t             cmd;

    logic [CDQ_DATA_W-1:0] cell_data [DEPTH];
    logic [CDQ_DATA_W-1:0] cell_tail [DEPTH];

    assign req_stall = rsp_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [CDQ_DATA_W-1:0] prev_d;
            logic [CDQ_DATA_W-1:0] next_d;
            if (gi == 0)
            begin : g_first
                assign prev_d = cmd.value;
            end
            else
            begin : g_mid
                assign prev_d = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign next_d = '0;
            end
            else
            begin : g_inner
                assign next_d = cell_data[gi+1];
            end
            cdq_cell #(
                .CELL_IDX (gi),
                .CNT_W    (CNT_W)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .count     (count_reg),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_data[gi]),
                .tail_data (cell_tail[gi])
            );
        end
    endgenerate

    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_value = tail_value | cell_tail[i];
        end
    end

    always_comb
    begin
        cmd.op      = CELL_HOLD;
        cmd.value   = push_value;
        count_next  = count_reg;
        status_next = ST_DONE;
        popped_next = '0;
        case (req_type)
            REQ_PUSH_FRONT,
            REQ_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.op     = (req_type == REQ_PUSH_FRONT) ? CELL_SHR : CELL_LOAD;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_POP_FRONT,
            REQ_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    if (req_type == REQ_POP_FRONT)
                    begin
                        cmd.op      = CELL_SHL;
                        popped_next = cell_data[0];
                    end
                    else
                    begin
                        popped_next = tail_value;
                    end
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
        if (!accept)
        begin
            cmd.op = CELL_HOLD;
        end
    end

    assign rsp_valid_next = accept | (rsp_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
            empty_reg  <= (count_next == '0);
            full_reg   <= (count_next == CNT_W'(DEPTH));
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign popped_value = signed'(popped_reg);
    assign now_empty    = empty_reg;
    assign now_full     = full_reg;

    `CDQ_ASSERT(a_count_range, count_reg <= CNT_W'(DEPTH), "occupancy above depth")
    `CDQ_ASSERT(a_refused_holds, (accept && status_next != ST_DONE) |=> $stable(count_reg), "refused request changed occupancy")
    `CDQ_ASSERT(a_flags_excl, rsp_valid |-> !(now_empty && now_full), "empty and full together")
    `CDQ_ASSERT(a_pop_ok, (accept && req_type[1] && !is_empty) |-> (status_next == ST_DONE), "pop refused with entries held")

endmodule
`default_nettype wire

FILE: test/circular_deque_checker.sv
// Checker for the circular deque: predicts each response and compares it as it leaves.
`default_nettype none
module circular_deque_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = CDQ_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    input  wire logic                  req_stall,
    input  wire logic [1:0]            req_type,
    input  wire logic [CDQ_DATA_W-1:0] push_value,
    input  wire logic                  rsp_valid,
    input  wire logic                  rsp_stall,
    input  wire logic [1:0]            status,
    input  wire logic [CDQ_DATA_W-1:0] popped_value,
    input  wire logic                  now_empty,
    input  wire logic                  now_full,
    output int                         fail_count,
    output int                         outstanding
);

    typedef struct {
        logic [1:0]            status;
        logic [CDQ_DATA_W-1:0] popped;
        logic                  empty;
        logic                  full;
    } deque_result_t;

    // shadow copy of the deque
    logic [CDQ_DATA_W-1:0] slots [DEPTH];
    int                    head_slot;
    int                    tail_slot;
    int                    fill_level;

    deque_result_t         due_responses [$];
    deque_result_t         want;
    int                    mismatches;

    function automatic deque_result_t apply_request(input logic [1:0] kind,
                                                    input logic [CDQ_DATA_W-1:0] value);
        deque_result_t r;
        r.status = ST_DONE;
        r.popped = '0;
        if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK)
        begin
            if (fill_level == DEPTH)
                r.status = ST_FULL;
            else if (kind == REQ_PUSH_FRONT)
            begin
                head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
                slots[head_slot] = value;
                fill_level++;
            end
            else
            begin
                slots[tail_slot] = value;
                tail_slot = (tail_slot == DEPTH - 1) ? 0 : tail_slot + 1;
                fill_level++;
            end
        end
        else
        begin
            if (fill_level == 0)
                r.status = ST_EMPTY;
            else if (kind == REQ_POP_FRONT)
            begin
                r.popped = slots[head_slot];
                head_slot = (head_slot == DEPTH - 1) ? 0 : head_slot + 1;
                fill_level--;
            end
            else
            begin
                tail_slot = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
                r.popped = slots[tail_slot];
                fill_level--;
            end
        end
        r.empty = (fill_level == 0);
        r.full  = (fill_level == DEPTH);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [CDQ_DATA_W-1:0] expected,
                                 input logic [CDQ_DATA_W-1:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_slot   = 0;
            tail_slot   = 0;
            fill_level  = 0;
            mismatches  = 0;
            due_responses.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                due_responses = {due_responses, apply_request(req_type, push_value)};
            if (rsp_valid && !rsp_stall)
            begin
                if (due_responses.size() == 0)
                begin
                    $display("%0t: expected no response, actual response with status %0d",
                             $time, status);
                    mismatches++;
                end
                else
                begin
                    want = due_responses[0];
                    due_responses.delete(0);
                    compare_field("status", CDQ_DATA_W'(want.status), CDQ_DATA_W'(status));
                    compare_field("popped_value", want.popped, popped_value);
                    compare_field("now_empty", CDQ_DATA_W'(want.empty),
                                  CDQ_DATA_W'(now_empty));
                    compare_field("now_full", CDQ_DATA_W'(want.full),
                                  CDQ_DATA_W'(now_full));
                end
            end
            outstanding <= due_responses.size();
            fail_count  <= mismatches;
        end
    end

endmodule
`default_nettype wire

FILE: test/tb_circular_deque.sv
// Testbench top for the circular deque: clock, reset, request stimulus and verdict.
`default_nettype none
module tb_circular_deque;
    import cdq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 484;

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         req_valid  = 1'b0;
    logic                         req_stall;
    logic [1:0]                   req_type   = REQ_PUSH_FRONT;
    logic signed [CDQ_DATA_W-1:0] push_value = '0;
    logic                         rsp_valid;
    logic                         rsp_stall  = 1'b0;
    logic [1:0]                   status;
    logic signed [CDQ_DATA_W-1:0] popped_value;
    logic                         now_empty;
    logic                         now_full;

    int fail_count;
    int outstanding;
    int send_idle_pct = 9;
    int recv_idle_pct = 63;
    int quiet_cycles  = 0;

    circular_deque dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .push_value   (push_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .popped_value (popped_value),
        .now_empty    (now_empty),
        .now_full     (now_full)
    );

    circular_deque_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .push_value   (push_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .popped_value (popped_value),
        .now_empty    (now_empty),
        .now_full     (now_full),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_req(input logic [1:0] kind, input logic [CDQ_DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_type   <= kind;
        push_value <= value;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // random words half the time, the corner values the other half
    function automatic logic [CDQ_DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [CDQ_DATA_W-1:0] pattern [4];
        logic [1:0]            kind;
        int                    push_pct;
        int                    run_left;

        pattern = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty pops, front wrap both ways, fill, refused pushes, drain with back wrap
        send_req(REQ_POP_FRONT, $urandom);
        send_req(REQ_POP_BACK, $urandom);
        send_req(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        send_req(REQ_PUSH_BACK, 32'h8000_0000);
        send_req(REQ_POP_BACK, $urandom);
        send_req(REQ_POP_FRONT, $urandom);
        for (int i = 0; i < 4; i++)
            send_req(REQ_PUSH_FRONT, pattern[i]);
        for (int i = 0; i < 4; i++)
            send_req(REQ_PUSH_BACK, ~pattern[3 - i] ^ 32'h0F0F_0F0F);
        send_req(REQ_PUSH_FRONT, 32'h1234_5678);
        send_req(REQ_PUSH_BACK, 32'h8765_4321);
        repeat (5) send_req(REQ_POP_BACK, $urandom);
        repeat (3) send_req(REQ_POP_FRONT, $urandom);
        send_req(REQ_POP_BACK, $urandom);

        push_pct = 50;
        run_left = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 9;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // runs of push-heavy, balanced or pop-heavy traffic drive the deque to full and empty
                if (run_left == 0)
                begin
                    case ($urandom_range(2))
                        0:       push_pct = 15;
                        1:       push_pct = 50;
                        default: push_pct = 85;
                    endcase
                    run_left = $urandom_range(40, 16);
                end
                run_left--;
                if ($urandom_range(99) < push_pct)
                    kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
                else
                    kind = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
                send_req(kind, pick_value());
            end
        end
        req_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
